### rtl/core/qte_pkg.sv
package qte_pkg;

  // Component width inside the datapath (Q1.14).
  localparam int Q_W        = 16;
  // Products and sums of components, exact in Q28.
  localparam int SUM_W      = 34;
  // Angles in Q16 degrees.
  localparam int ANG_W      = 26;
  // Square root unit: radicand up to 2^56, root up to 2^28.
  localparam int RT_W       = 58;
  localparam int ROOT_W     = 29;
  localparam int ISQ_STAGES = 29;
  // CORDIC datapath and operand normalisation.
  localparam int CORD_W     = 64;
  localparam int NORM_STEPS = 6;
  localparam int NORM_EXP   = 58;
  localparam int ATAN_N     = 32;
  // Output field widths.
  localparam int ROLL_W     = 16;
  localparam int PITCH_W    = 15;
  localparam int YAW_W      = 16;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [ANG_W-1:0] angle_t;

  localparam sum_t   ONE_Q28 = 34'sd268435456;
  localparam angle_t DEG90   = 26'sd5898240;
  localparam angle_t DEG180  = 26'sd11796480;
  localparam angle_t DEG360  = 26'sd23592960;

  // atan(2^-i) in Q16 degrees, rounded to nearest.
  localparam angle_t ATAN_TAB [ATAN_N] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0
  };

  // Everything a request carries alongside the square root pipeline.
  typedef struct packed {
    logic valid;
    logic clamped;
    sum_t sr;
    sum_t cr;
    sum_t sp;
    sum_t sy;
    sum_t cy;
  } isq_side_t;

endpackage

### rtl/core/qte_isqrt.sv
module qte_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [qte_pkg::RT_W-1:0]    rem,
  input  qte_pkg::isq_side_t          side_in,
  output logic [qte_pkg::ROOT_W-1:0]  root,
  output qte_pkg::isq_side_t          side_out
);
  import qte_pkg::*;

  logic [RT_W-1:0] v_q [ISQ_STAGES];
  logic [RT_W-1:0] r_q [ISQ_STAGES];
  isq_side_t       s_q [ISQ_STAGES];

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_st
    localparam logic [RT_W-1:0] BITK = RT_W'(1) << (2 * (ISQ_STAGES - 1 - k));
    logic [RT_W-1:0] v_i;
    logic [RT_W-1:0] r_i;
    logic [RT_W-1:0] trial;
    isq_side_t       s_i;

    if (k == 0) begin : g_head
      assign v_i = rem;
      assign r_i = '0;
      assign s_i = side_in;
    end else begin : g_body
      assign v_i = v_q[k-1];
      assign r_i = r_q[k-1];
      assign s_i = s_q[k-1];
    end

    assign trial = r_i + BITK;

    always_ff @(posedge clk) begin
      if (v_i >= trial) begin
        v_q[k] <= v_i - trial;
        r_q[k] <= (r_i >> 1) + BITK;
      end else begin
        v_q[k] <= v_i;
        r_q[k] <= r_i >> 1;
      end
      if (rst) begin
        s_q[k] <= '0;
      end else begin
        s_q[k] <= s_i;
      end
    end
  end

  assign root     = r_q[ISQ_STAGES-1][ROOT_W-1:0];
  assign side_out = s_q[ISQ_STAGES-1];

endmodule

### rtl/core/qte_cordic.sv
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  logic            clk,
  input  qte_pkg::sum_t   y_in,
  input  qte_pkg::sum_t   x_in,
  output qte_pkg::angle_t angle
);
  import qte_pkg::*;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    angle_t                   z;
    logic                     zero;
    logic                     xneg;
  } cst_t;

  cst_t pre_next;
  cst_t pre_q;
  cst_t norm_q [NORM_STEPS];
  cst_t rot_q  [STAGES];

  // A vector in the left half plane is first turned by a quarter turn.
  always_comb begin
    pre_next.x    = CORD_W'(x_in);
    pre_next.y    = CORD_W'(y_in);
    pre_next.z    = '0;
    pre_next.zero = (y_in == '0);
    pre_next.xneg = (x_in < 0);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        pre_next.x = CORD_W'(y_in);
        pre_next.y = -CORD_W'(x_in);
        pre_next.z = DEG90;
      end else begin
        pre_next.x = -CORD_W'(y_in);
        pre_next.y = CORD_W'(x_in);
        pre_next.z = -DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    pre_q <= pre_next;
  end

  // Binary search for the left shift that lifts the larger operand to 2^58.
  // Each step tries one power of two; the last adds the final single shift.
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - 1 - j);
    localparam logic [CORD_W-1:0] LIM = CORD_W'(1) << (NORM_EXP - SH);
    cst_t            cur;
    cst_t            nxt;
    logic [CORD_W-1:0] ax;
    logic [CORD_W-1:0] ay;

    if (j == 0) begin : g_head
      assign cur = pre_q;
    end else begin : g_body
      assign cur = norm_q[j-1];
    end

    always_comb begin
      ax  = (cur.x < 0) ? -cur.x : cur.x;
      ay  = (cur.y < 0) ? -cur.y : cur.y;
      nxt = cur;
      if (ax < LIM && ay < LIM) begin
        nxt.x = cur.x <<< SH;
        nxt.y = cur.y <<< SH;
      end
      if (j == NORM_STEPS - 1) begin
        nxt.x = nxt.x <<< 1;
        nxt.y = nxt.y <<< 1;
      end
    end

    always_ff @(posedge clk) begin
      norm_q[j] <= nxt;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam angle_t A = ATAN_TAB[i % ATAN_N];
    cst_t                     cur;
    cst_t                     nxt;
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;

    if (i == 0) begin : g_head
      assign cur = norm_q[NORM_STEPS-1];
    end else begin : g_body
      assign cur = rot_q[i-1];
    end

    always_comb begin
      xs  = cur.x >>> i;
      ys  = cur.y >>> i;
      nxt = cur;
      if (cur.y >= 0) begin
        nxt.x = cur.x + ys;
        nxt.y = cur.y - xs;
        nxt.z = cur.z + A;
      end else begin
        nxt.x = cur.x - ys;
        nxt.y = cur.y + xs;
        nxt.z = cur.z - A;
      end
    end

    always_ff @(posedge clk) begin
      rot_q[i] <= nxt;
    end
  end

  // A zero sine operand bypasses the iterations altogether.
  always_comb begin
    if (rot_q[STAGES-1].zero) begin
      angle = rot_q[STAGES-1].xneg ? DEG180 : '0;
    end else begin
      angle = rot_q[STAGES-1].z;
    end
  end

endmodule

### rtl/core/quaternion_to_euler_degrees.sv
// Quaternion to Z-Y-X Euler angles in degrees.
// Request channel: quat_x, quat_y, quat_z and quat_w are taken at a rising
// edge with start high and busy low. busy is always low, so a new request
// may be issued in every clock cycle.
// Result channel: roll_angle, pitch_angle, yaw_angle and pitch_clamped are
// valid for the single cycle in which done is high. Angles are in units of
// 1/2^ANGLE_FRACTION_BITS degree; pitch_clamped marks a pitch sine that
// reached one in magnitude, in which case pitch is exactly +/-90 degrees.
// Throughput is one request per cycle. Each request passes through the
// 29-stage square root for the pitch cosine followed by the CORDIC
// pipeline (one rotation, six normalisation stages and CORDIC_STAGES
// iterations), with roll and yaw travelling alongside. Results come one
// for each request, in request order.
// Synchronous reset clears every valid bit; requests in flight are dropped.
// The receiver cannot hold results off and there is no back-pressure.
module quaternion_to_euler_degrees #(
  parameter int COMPONENT_WIDTH     = 16,
  parameter int ANGLE_FRACTION_BITS = 7,
  parameter int CORDIC_STAGES       = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COMPONENT_WIDTH-1:0]   quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0]   quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0]   quat_z,
  input  logic signed [COMPONENT_WIDTH-1:0]   quat_w,
  output logic                                done,
  output logic signed [qte_pkg::ROLL_W-1:0]   roll_angle,
  output logic signed [qte_pkg::PITCH_W-1:0]  pitch_angle,
  output logic signed [qte_pkg::YAW_W-1:0]    yaw_angle,
  output logic                                pitch_clamped
);
  import qte_pkg::*;

  localparam int CL  = 1 + NORM_STEPS + CORDIC_STAGES;
  localparam int LAT = 4 + ISQ_STAGES + CL + 2;
  localparam int K   = 16 - ANGLE_FRACTION_BITS;
  localparam angle_t HALF = angle_t'((1 << K) >> 1);

  typedef struct packed {
    logic valid;
    logic clamped;
    logic neg;
  } tail_t;

  assign busy = 1'b0;

  // Bring each component to Q1.14.
  logic signed [Q_W-1:0] lx, ly, lz, lw;
  if (COMPONENT_WIDTH > Q_W) begin : g_wide
    assign lx = quat_x[COMPONENT_WIDTH-1 -: Q_W];
    assign ly = quat_y[COMPONENT_WIDTH-1 -: Q_W];
    assign lz = quat_z[COMPONENT_WIDTH-1 -: Q_W];
    assign lw = quat_w[COMPONENT_WIDTH-1 -: Q_W];
  end else if (COMPONENT_WIDTH < Q_W) begin : g_narrow
    assign lx = {quat_x, {(Q_W - COMPONENT_WIDTH){1'b0}}};
    assign ly = {quat_y, {(Q_W - COMPONENT_WIDTH){1'b0}}};
    assign lz = {quat_z, {(Q_W - COMPONENT_WIDTH){1'b0}}};
    assign lw = {quat_w, {(Q_W - COMPONENT_WIDTH){1'b0}}};
  end else begin : g_same
    assign lx = quat_x;
    assign ly = quat_y;
    assign lz = quat_z;
    assign lw = quat_w;
  end

  // Stage 1: components.
  logic                  v1;
  logic signed [Q_W-1:0] qx, qy, qz, qw;

  always_ff @(posedge clk) begin
    qx <= lx;
    qy <= ly;
    qz <= lz;
    qw <= lw;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  // Stage 2: the nine products.
  logic                      v2;
  logic signed [2*Q_W-1:0]   pxx, pyy, pzz, pwx, pyz, pwy, pzx, pwz, pxy;

  always_ff @(posedge clk) begin
    pxx <= qx * qx;
    pyy <= qy * qy;
    pzz <= qz * qz;
    pwx <= qw * qx;
    pyz <= qy * qz;
    pwy <= qw * qy;
    pzx <= qz * qx;
    pwz <= qw * qz;
    pxy <= qx * qy;
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // Stage 3: sine and cosine operands in Q28.
  isq_side_t s3, s3_next;

  always_comb begin
    s3_next.valid   = v2;
    s3_next.sr      = (SUM_W'(pwx) + SUM_W'(pyz)) <<< 1;
    s3_next.cr      = ONE_Q28 - ((SUM_W'(pxx) + SUM_W'(pyy)) <<< 1);
    s3_next.sp      = (SUM_W'(pwy) - SUM_W'(pzx)) <<< 1;
    s3_next.sy      = (SUM_W'(pwz) + SUM_W'(pxy)) <<< 1;
    s3_next.cy      = ONE_Q28 - ((SUM_W'(pyy) + SUM_W'(pzz)) <<< 1);
    s3_next.clamped = (s3_next.sp >= ONE_Q28) || (s3_next.sp <= -ONE_Q28);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else begin
      s3 <= s3_next;
    end
  end

  // Stage 4: square of the pitch sine; only meaningful when not clamped.
  isq_side_t       s4;
  logic [RT_W-1:0] sq;
  logic [RT_W-1:0] rem;

  always_ff @(posedge clk) begin
    sq <= $signed(s3.sp[ROOT_W-1:0]) * $signed(s3.sp[ROOT_W-1:0]);
    if (rst) begin
      s4 <= '0;
    end else begin
      s4 <= s3;
    end
  end

  assign rem = (RT_W'(1) << (2 * (ROOT_W - 1))) - sq;

  logic [ROOT_W-1:0] root;
  isq_side_t         s5;

  qte_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .rem      (rem),
    .side_in  (s4),
    .root     (root),
    .side_out (s5)
  );

  angle_t roll_z, yaw_z, pitch_z;

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .y_in  (s5.sr),
    .x_in  (s5.cr),
    .angle (roll_z)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .y_in  (s5.sy),
    .x_in  (s5.cy),
    .angle (yaw_z)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .y_in  (s5.sp),
    .x_in  ($signed(SUM_W'(root))),
    .angle (pitch_z)
  );

  // Valid, clamp and pitch sign bits keep pace with the CORDIC pipeline.
  tail_t tail_q [CL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CL; k++) begin
        tail_q[k] <= '0;
      end
    end else begin
      tail_q[0] <= '{valid: s5.valid, clamped: s5.clamped, neg: (s5.sp < 0)};
      for (int k = 1; k < CL; k++) begin
        tail_q[k] <= tail_q[k-1];
      end
    end
  end

  function automatic angle_t wrap180(input angle_t z);
    angle_t r;
    r = z;
    if (z > DEG180) begin
      r = z - DEG360;
    end else if (z <= -DEG180) begin
      r = z + DEG360;
    end
    return r;
  endfunction

  // Stage F1: wrap roll and yaw, settle pitch.
  logic   f1_valid;
  logic   f1_clamped;
  angle_t roll_w, yaw_w, pitch_c;

  always_ff @(posedge clk) begin
    roll_w     <= wrap180(roll_z);
    yaw_w      <= wrap180(yaw_z);
    f1_clamped <= tail_q[CL-1].clamped;
    if (tail_q[CL-1].clamped) begin
      pitch_c <= tail_q[CL-1].neg ? -DEG90 : DEG90;
    end else if (pitch_z > DEG90) begin
      pitch_c <= DEG90;
    end else if (pitch_z < -DEG90) begin
      pitch_c <= -DEG90;
    end else begin
      pitch_c <= pitch_z;
    end
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= tail_q[CL-1].valid;
    end
  end

  // Stage F2: round to the output unit.
  angle_t roll_r, pitch_r, yaw_r;

  assign roll_r  = (roll_w + HALF) >>> K;
  assign pitch_r = (pitch_c + HALF) >>> K;
  assign yaw_r   = (yaw_w + HALF) >>> K;

  always_ff @(posedge clk) begin
    roll_angle    <= roll_r[ROLL_W-1:0];
    pitch_angle   <= pitch_r[PITCH_W-1:0];
    yaw_angle     <= yaw_r[YAW_W-1:0];
    pitch_clamped <= f1_clamped;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f1_valid;
    end
  end

`ifndef NO_ASSERTIONS
  localparam logic [PITCH_W-1:0] P90_F = PITCH_W'((DEG90 + HALF) >>> K);
  localparam logic [PITCH_W-1:0] N90_F = PITCH_W'((-DEG90 + HALF) >>> K);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a request accepted the fixed latency earlier");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    f1_valid |-> (roll_w > -DEG180 && roll_w <= DEG180 &&
                  yaw_w > -DEG180 && yaw_w <= DEG180))
    else $error("roll or yaw outside the half-open range of one turn");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    f1_valid |-> (pitch_c >= -DEG90 && pitch_c <= DEG90))
    else $error("pitch beyond a quarter turn");

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (done && pitch_clamped) |-> (pitch_angle == P90_F || pitch_angle == N90_F))
    else $error("clamped pitch is not exactly a quarter turn");
`endif

endmodule

### dv/quaternion_to_euler_degrees_tb.sv
`timescale 1ns / 1ps

class euler_scoreboard;
  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } angles_t;

  angles_t pending_angles[$];
  int      mismatches;
  int      checked;
  int      clamp_seen;

  function longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function longint int_sqrt(longint v);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC, angle returned in Q16 degrees.
  function longint vector_angle(longint yv, longint xv);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (yv == 0) return xv < 0 ? longint'(qte_pkg::DEG180) : 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; z = qte_pkg::DEG90;
      end else begin
        xv = -yv; yv = t; z = -longint'(qte_pkg::DEG90);
      end
    end
    while (iabs(xv) < (64'sd1 <<< 58) && iabs(yv) < (64'sd1 <<< 58)) begin
      xv = xv * 2;
      yv = yv * 2;
    end
    for (int i = 0; i < 16; i++) begin
      xs = asr(xv, i);
      ys = asr(yv, i);
      if (yv >= 0) begin
        xv = xv + ys; yv = yv - xs; z = z + qte_pkg::ATAN_TAB[i];
      end else begin
        xv = xv - ys; yv = yv + xs; z = z - qte_pkg::ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function longint wrap_half_turn(longint z);
    if (z > qte_pkg::DEG180) return z - qte_pkg::DEG360;
    if (z <= -longint'(qte_pkg::DEG180)) return z + qte_pkg::DEG360;
    return z;
  endfunction

  function longint to_units(longint z);
    return asr(z + 256, 9);
  endfunction

  function void note_request(logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz, logic signed [15:0] qw);
    longint x, y, z, w, sr, cr, sp, sy, cy, pitch;
    angles_t a;
    x = qx; y = qy; z = qz; w = qw;
    sr = 2 * (w * x + y * z);
    cr = (64'sd1 <<< 28) - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = (64'sd1 <<< 28) - 2 * (y * y + z * z);
    a.clamped = iabs(sp) >= (64'sd1 <<< 28);
    if (a.clamped) begin
      pitch = sp < 0 ? -longint'(qte_pkg::DEG90) : longint'(qte_pkg::DEG90);
    end else begin
      pitch = vector_angle(sp, int_sqrt((64'sd1 <<< 56) - sp * sp));
      if (pitch > qte_pkg::DEG90) pitch = qte_pkg::DEG90;
      if (pitch < -longint'(qte_pkg::DEG90)) pitch = -longint'(qte_pkg::DEG90);
    end
    a.roll  = 16'(to_units(wrap_half_turn(vector_angle(sr, cr))));
    a.pitch = 15'(to_units(pitch));
    a.yaw   = 16'(to_units(wrap_half_turn(vector_angle(sy, cy))));
    pending_angles.push_back(a);
  endfunction

  function void check_result(logic signed [15:0] roll, logic signed [14:0] pitch,
                             logic signed [15:0] yaw, logic clamped);
    angles_t e;
    if (pending_angles.size() == 0) begin
      $error("result with no request outstanding");
      mismatches++;
      return;
    end
    e = pending_angles.pop_front();
    checked++;
    if (clamped) clamp_seen++;
    if (roll !== e.roll) begin
      $error("roll_angle: expected %0d, got %0d", e.roll, roll);
      mismatches++;
    end
    if (pitch !== e.pitch) begin
      $error("pitch_angle: expected %0d, got %0d", e.pitch, pitch);
      mismatches++;
    end
    if (yaw !== e.yaw) begin
      $error("yaw_angle: expected %0d, got %0d", e.yaw, yaw);
      mismatches++;
    end
    if (clamped !== e.clamped) begin
      $error("pitch_clamped: expected %0d, got %0d", e.clamped, clamped);
      mismatches++;
    end
  endfunction
endclass

module quaternion_to_euler_degrees_tb;
  localparam int LATENCY = 58;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic done;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic pitch_clamped;

  euler_scoreboard sb;
  int idle_pct;
  int idle_cycles;
  int requests_sent;
  bit timed_out;

  quaternion_to_euler_degrees u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(roll_angle, pitch_angle, yaw_angle, pitch_clamped);
  end

  // Counts cycles in which no request and no result is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Issues one request and holds it until accepted; start stays high when the
  // next request follows without a gap.
  task automatic send_request(logic signed [15:0] qx, logic signed [15:0] qy,
                              logic signed [15:0] qz, logic signed [15:0] qw);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
    do @(posedge clk); while (busy);
    sb.note_request(qx, qy, qz, qw);
    requests_sent++;
  endtask

  task automatic send_unit_quaternion();
    real a, b, c, d, n;
    a = $urandom_range(2000) - 1000.0;
    b = $urandom_range(2000) - 1000.0;
    c = $urandom_range(2000) - 1000.0;
    d = $urandom_range(2000) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    send_request(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                 16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
  endtask

  // Gimbal lock: rotation of +-90 degrees about Y, with a little noise so
  // the sine lands on both sides of one.
  task automatic send_near_gimbal_lock();
    logic signed [15:0] s;
    s = 16'(11585 + $urandom_range(8) - 4);
    if ($urandom_range(1)) send_request(16'($urandom_range(6) - 3), s,
                                        16'($urandom_range(6) - 3), s);
    else send_request(16'($urandom_range(6) - 3), -s, 16'($urandom_range(6) - 3), s);
  endtask

  initial begin
    int phase_pct [4] = '{0, 52, 0, 32};
    logic signed [15:0] corner [6] = '{16'sh7fff, -16'sh8000, 16'sh4000,
                                        -16'sh4000, 16'sh0000, 16'sh0001};
    sb = new();
    start = 1'b0;
    quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
    rst = 1'b1;
    idle_pct = 0;
    requests_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity, axis half-turns, extremes, zero quaternion and quarter turns.
    send_request(0, 0, 0, 16'sh4000);
    send_request(16'sh4000, 0, 0, 0);
    send_request(0, 16'sh4000, 0, 0);
    send_request(0, 0, 16'sh4000, 0);
    send_request(0, 0, 0, 0);
    send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_request(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_request(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff);
    send_request(0, 16'sh2d41, 0, 16'sh2d41);
    send_request(0, -16'sh2d41, 0, 16'sh2d41);
    send_request(16'sh2d41, 0, 0, -16'sh2d41);
    send_request(0, 0, -16'sh2d41, 16'sh2d41);
    for (int i = 0; i < 12; i++)
      send_request(corner[$urandom_range(5)], corner[$urandom_range(5)],
                   corner[$urandom_range(5)], corner[$urandom_range(5)]);

    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      for (int i = 0; i < 300; i++) begin
        case ($urandom_range(9))
          0, 1:    send_request(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom));
          2:       send_near_gimbal_lock();
          default: send_unit_quaternion();
        endcase
        if ($urandom_range(49) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(40, 1)) @(posedge clk);
        end
      end
    end
    start <= 1'b0;

    while (sb.pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d with pitch clamped",
             requests_sent, sb.checked, sb.clamp_seen);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
